FILE: src/smfu_pkg.sv
// ----------------------------------------------------------------------------
// smfu_pkg
// Shared codes, widths and types of the stack machine frame unit.
// ----------------------------------------------------------------------------
package smfu_pkg;

   // Fixed field widths
   localparam int DATA_BITS = 32;
   localparam int PC_BITS   = 16;
   localparam int IDX_BITS  = 10;
   localparam int FP_BITS   = 6;
   localparam int SIZE_BITS = 11;   // frame size: up to two 10-bit counts

   // Invoke jumps past the method header
   localparam logic [PC_BITS-1:0] PC_ENTRY_OFFSET = 16'd3;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_LOAD   = 3'd2,
      OP_STORE  = 3'd3,
      OP_INVOKE = 3'd4,
      OP_RETURN = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_UNDER    = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_NOFRAME  = 3'd4,
      ST_RANGE    = 3'd5,
      ST_UNINIT   = 3'd6
   } status_type;

   // Verdict on one word before any state changes
   typedef struct packed {
      status_type status;
      logic       ok;
   } check_type;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_EXEC   = 7'b0000100,
      S_LOAD   = 7'b0001000,
      S_WALK   = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

endpackage

FILE: src/smfu_if.sv
// ----------------------------------------------------------------------------
// smfu_req_if / smfu_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface smfu_req_if import smfu_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [2:0]                  operation;
   logic signed [DATA_BITS-1:0] value;
   logic [IDX_BITS-1:0]         local_index;
   logic [PC_BITS-1:0]          method_addr;
   logic [IDX_BITS-1:0]         arg_count;
   logic [IDX_BITS-1:0]         local_count;
   logic [PC_BITS-1:0]          current_pc;

   modport source (output valid, operation, value, local_index, method_addr,
                   arg_count, local_count, current_pc, input ready);
   modport sink   (input valid, operation, value, local_index, method_addr,
                   arg_count, local_count, current_pc, output ready);
endinterface

interface smfu_rsp_if import smfu_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] data;
   logic [PC_BITS-1:0]          new_pc;
   logic                        pc_valid;
   logic [FP_BITS-1:0]          frame_pointer_out;
   logic [2:0]                  status;

   modport source (output valid, data, new_pc, pc_valid, frame_pointer_out, status,
                   input ready);
   modport sink   (input valid, data, new_pc, pc_valid, frame_pointer_out, status,
                   output ready);
endinterface

FILE: src/smfu_check.sv
// ----------------------------------------------------------------------------
// smfu_check
// Checks one request word against stack and frame state; gives status,
// local address, and the base and size of a frame to be opened.
// ----------------------------------------------------------------------------
module smfu_check import smfu_pkg::*; #(
   parameter int STACK_DEPTH  = 1024,
   parameter int FRAME_LIMIT  = 64,
   parameter int LOCALS_DEPTH = 4096,
   localparam int SCW = $clog2(STACK_DEPTH + 1),
   localparam int FCW = $clog2(FRAME_LIMIT + 1),
   localparam int LAW = $clog2(LOCALS_DEPTH),
   localparam int LBW = $clog2(LOCALS_DEPTH + 1)
) (
   input  op_type              operation,
   input  logic [IDX_BITS-1:0] local_index,
   input  logic [IDX_BITS-1:0] arg_count,
   input  logic [IDX_BITS-1:0] local_count,
   input  logic [SCW-1:0]      stack_count,
   input  logic [FCW-1:0]      frame_count,
   input  logic [LBW-1:0]      top_base,
   input  logic [SIZE_BITS-1:0] top_size,
   output check_type           chk,
   output logic [LAW-1:0]      local_addr,
   output logic [LBW-1:0]      new_base,
   output logic [SIZE_BITS-1:0] total
);

   localparam int SUMW = ((LBW > SIZE_BITS) ? LBW : SIZE_BITS) + 2;

   logic [SUMW-1:0] local_sum;
   logic [SUMW-1:0] base_sum;
   logic [SUMW-1:0] end_sum;
   logic            no_frame;

   // Address arithmetic
   assign no_frame   = (frame_count == '0);
   assign local_sum  = SUMW'(top_base) + SUMW'(local_index);
   assign base_sum   = no_frame ? '0 : SUMW'(top_base) + SUMW'(top_size);
   assign total      = SIZE_BITS'(arg_count) + SIZE_BITS'(local_count);
   assign end_sum    = base_sum + SUMW'(total);
   assign local_addr = LAW'(local_sum);
   assign new_base   = LBW'(base_sum);

   // Status per operation
   always_comb begin
      chk = '{status: ST_OK, ok: 1'b1};
      unique case (operation)
         OP_PUSH: begin
            if (stack_count >= SCW'(STACK_DEPTH)) chk = '{status: ST_FULL, ok: 1'b0};
         end
         OP_POP: begin
            if (stack_count == '0) chk = '{status: ST_UNDER, ok: 1'b0};
         end
         OP_LOAD, OP_STORE: begin
            priority if (no_frame) chk = '{status: ST_NOFRAME, ok: 1'b0};
            else if (SIZE_BITS'(local_index) >= top_size)
               chk = '{status: ST_RANGE, ok: 1'b0};
            else if (local_sum >= SUMW'(LOCALS_DEPTH))
               chk = '{status: ST_RANGE, ok: 1'b0};
         end
         OP_INVOKE: begin
            priority if (frame_count >= FCW'(FRAME_LIMIT))
               chk = '{status: ST_OVERFLOW, ok: 1'b0};
            else if (end_sum > SUMW'(LOCALS_DEPTH))
               chk = '{status: ST_OVERFLOW, ok: 1'b0};
            else if (32'(stack_count) < 32'(arg_count))
               chk = '{status: ST_UNDER, ok: 1'b0};
         end
         OP_RETURN: begin
            priority if (no_frame) chk = '{status: ST_NOFRAME, ok: 1'b0};
            else if (stack_count == '0) chk = '{status: ST_UNDER, ok: 1'b0};
         end
         default: chk = '{status: ST_OK, ok: 1'b1};
      endcase
   end

endmodule

FILE: src/stack_machine_frame_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_frame_unit
// Operand stack and call-frame unit of a stack virtual machine.
// ----------------------------------------------------------------------------
// One request word is handled at a time and gives one response word. After
// reset the unit sweeps its local-written flags before it takes the first
// request. Push, pop, store and return go from the accept through S_EXEC to
// the response register; load adds S_LOAD (locals read); invoke goes through
// S_WALK and S_FINISH: a walk over the new frame, one local per cycle through
// the single write port of the locals memories after a first step that
// primes the operand read, copying one argument from the operand memory in
// each argument step. The next request is taken once the response has been
// taken. Errors report a status and change no state.
module stack_machine_frame_unit import smfu_pkg::*; #(
   parameter int STACK_DEPTH  = 1024,
   parameter int FRAME_LIMIT  = 64,
   parameter int MAIN_LOCALS  = 256,
   parameter int LOCALS_DEPTH = 4096,
   parameter int WORD_BITS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   smfu_req_if.sink   req,
   smfu_rsp_if.source rsp
);

   localparam int SCW = $clog2(STACK_DEPTH + 1);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int FCW = $clog2(FRAME_LIMIT + 1);
   localparam int FAW = $clog2(FRAME_LIMIT);
   localparam int LAW = $clog2(LOCALS_DEPTH);
   localparam int LBW = $clog2(LOCALS_DEPTH + 1);

   // Memories
   logic [WORD_BITS-1:0] operand_mem [STACK_DEPTH];
   logic [WORD_BITS-1:0] locals_mem  [LOCALS_DEPTH];
   logic                 written_mem [LOCALS_DEPTH];
   logic [LBW-1:0]       fbase_mem   [FRAME_LIMIT];
   logic [SIZE_BITS-1:0] fsize_mem   [FRAME_LIMIT];
   logic [PC_BITS-1:0]   fpc_mem     [FRAME_LIMIT];
   logic [FP_BITS-1:0]   ffp_mem     [FRAME_LIMIT];

   // Control state
   state_type            state_ff, state_in;
   logic [SCW-1:0]       stack_count_ff, stack_count_in;
   logic [FCW-1:0]       frame_count_ff, frame_count_in;
   logic [FP_BITS-1:0]   fp_ff, fp_in;
   logic                 frame0_ff, frame0_in;
   logic [LAW-1:0]       clear_ff, clear_in;
   logic [SIZE_BITS-1:0] walk_ff, walk_in;

   // Request word and walk bookkeeping
   op_type                      op_ff;
   logic signed [DATA_BITS-1:0] value_ff;
   logic [IDX_BITS-1:0]         idx_ff, nargs_ff, nloc_ff;
   logic [PC_BITS-1:0]          maddr_ff, cpc_ff;
   logic [LBW-1:0]              wbase_ff, wbase_in;
   logic [SCW-1:0]              sbase_ff, sbase_in;

   // Response register
   logic signed [DATA_BITS-1:0] data_ff, data_in;
   logic [PC_BITS-1:0]          npc_ff, npc_in;
   logic                        pcv_ff, pcv_in;
   status_type                  status_ff, status_in;

   // Memory read data
   logic [WORD_BITS-1:0] op_rdata, loc_rdata;
   logic                 wr_rdata;
   logic [LBW-1:0]       fbase_rdata;
   logic [SIZE_BITS-1:0] fsize_rdata;
   logic [PC_BITS-1:0]   fpc_rdata;
   logic [FP_BITS-1:0]   ffp_rdata;

   // Memory controls
   logic                 op_we, loc_we, wr_we, wr_wdata, fr_we;
   logic [SAW-1:0]       op_waddr, op_raddr;
   logic [WORD_BITS-1:0] op_wdata, loc_wdata;
   logic [LAW-1:0]       loc_waddr, wr_waddr;
   logic [FAW-1:0]       fr_raddr, fr_waddr;

   logic                 accept;
   logic                 top_init;
   logic [LBW-1:0]       top_base;
   logic [SIZE_BITS-1:0] top_size;
   logic [PC_BITS-1:0]   top_pc;
   logic [FP_BITS-1:0]   top_fp;
   logic [WORD_BITS-1:0] word_in;
   check_type            chk;
   logic [LAW-1:0]       local_addr;
   logic [LBW-1:0]       new_base;
   logic [SIZE_BITS-1:0] total;
   logic [SIZE_BITS-1:0] walk_idx;
   logic                 walk_arg;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   assign rsp.valid             = (state_ff == S_RESP);
   assign rsp.data              = data_ff;
   assign rsp.new_pc            = npc_ff;
   assign rsp.pc_valid          = pcv_ff;
   assign rsp.frame_pointer_out = fp_ff;
   assign rsp.status            = status_ff;

   assign word_in = WORD_BITS'(value_ff);

   // Top frame; constants stand in for entry 0 as the main frame until entry 0 is first written
   assign top_init = (frame_count_ff == FCW'(1)) && !frame0_ff;
   assign top_base = top_init ? '0 : fbase_rdata;
   assign top_size = top_init ? SIZE_BITS'(MAIN_LOCALS) : fsize_rdata;
   assign top_pc   = top_init ? '0 : fpc_rdata;
   assign top_fp   = top_init ? '0 : ffp_rdata;

   smfu_check #(
      .STACK_DEPTH  (STACK_DEPTH),
      .FRAME_LIMIT  (FRAME_LIMIT),
      .LOCALS_DEPTH (LOCALS_DEPTH)
   ) u_check (
      .operation   (op_ff),
      .local_index (idx_ff),
      .arg_count   (nargs_ff),
      .local_count (nloc_ff),
      .stack_count (stack_count_ff),
      .frame_count (frame_count_ff),
      .top_base    (top_base),
      .top_size    (top_size),
      .chk         (chk),
      .local_addr  (local_addr),
      .new_base    (new_base),
      .total       (total)
   );

   // Walk step k writes local k-1 of the new frame
   assign walk_idx = walk_ff - SIZE_BITS'(1);
   assign walk_arg = (walk_idx < SIZE_BITS'(nargs_ff));

   // Read addresses
   assign fr_raddr = FAW'(frame_count_ff - FCW'(1));
   assign op_raddr = (state_ff == S_WALK) ? SAW'(32'(sbase_ff) + 32'(walk_ff))
                                          : SAW'(stack_count_ff - SCW'(1));

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      stack_count_in = stack_count_ff;
      frame_count_in = frame_count_ff;
      fp_in          = fp_ff;
      frame0_in      = frame0_ff;
      clear_in       = clear_ff;
      walk_in        = walk_ff;
      wbase_in       = wbase_ff;
      sbase_in       = sbase_ff;
      data_in        = data_ff;
      npc_in         = npc_ff;
      pcv_in         = pcv_ff;
      status_in      = status_ff;
      op_we     = 1'b0;
      op_waddr  = SAW'(stack_count_ff);
      op_wdata  = word_in;
      loc_we    = 1'b0;
      loc_waddr = local_addr;
      loc_wdata = word_in;
      wr_we     = 1'b0;
      wr_waddr  = local_addr;
      wr_wdata  = 1'b1;
      fr_we     = 1'b0;
      fr_waddr  = FAW'(frame_count_ff);

      unique case (state_ff)
         S_CLEAR: begin
            wr_we    = 1'b1;
            wr_waddr = clear_ff;
            wr_wdata = 1'b0;
            clear_in = clear_ff + LAW'(1);
            if (clear_ff == LAW'(LOCALS_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            data_in   = '0;
            npc_in    = '0;
            pcv_in    = 1'b0;
            status_in = chk.status;
            state_in  = S_RESP;
            if (chk.ok) begin
               unique case (op_ff)
                  OP_PUSH: begin
                     op_we          = 1'b1;
                     stack_count_in = stack_count_ff + SCW'(1);
                  end
                  OP_POP: begin
                     data_in        = DATA_BITS'(op_rdata);
                     stack_count_in = stack_count_ff - SCW'(1);
                  end
                  OP_LOAD: state_in = S_LOAD;
                  OP_STORE: begin
                     loc_we = 1'b1;
                     wr_we  = 1'b1;
                  end
                  OP_INVOKE: begin
                     wbase_in = new_base;
                     sbase_in = stack_count_ff - SCW'(nargs_ff);
                     walk_in  = '0;
                     state_in = S_WALK;
                  end
                  OP_RETURN: begin
                     data_in        = DATA_BITS'(op_rdata);
                     npc_in         = top_pc;
                     pcv_in         = 1'b1;
                     fp_in          = top_fp;
                     frame_count_in = frame_count_ff - FCW'(1);
                  end
                  default: ;
               endcase
            end
         end
         S_LOAD: begin
            if (wr_rdata) begin
               data_in = DATA_BITS'(loc_rdata);
            end else begin
               status_in = ST_UNINIT;
            end
            state_in = S_RESP;
         end
         S_WALK: begin
            // argument copy first, then clearing of the extra locals
            if (walk_ff != '0) begin
               wr_we     = 1'b1;
               wr_waddr  = LAW'(32'(wbase_ff) + 32'(walk_idx));
               wr_wdata  = walk_arg;
               loc_we    = walk_arg;
               loc_waddr = LAW'(32'(wbase_ff) + 32'(walk_idx));
               loc_wdata = op_rdata;
            end
            walk_in = walk_ff + SIZE_BITS'(1);
            if (walk_ff == total) state_in = S_FINISH;
         end
         S_FINISH: begin
            fr_we          = 1'b1;
            stack_count_in = sbase_ff;
            frame_count_in = frame_count_ff + FCW'(1);
            fp_in          = FP_BITS'(frame_count_ff);
            if (frame_count_ff == '0) frame0_in = 1'b1;
            npc_in         = maddr_ff + PC_ENTRY_OFFSET;
            pcv_in         = 1'b1;
            status_in      = ST_OK;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         stack_count_ff <= '0;
         frame_count_ff <= FCW'(1);
         fp_ff          <= '0;
         frame0_ff      <= 1'b0;
         clear_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         stack_count_ff <= stack_count_in;
         frame_count_ff <= frame_count_in;
         fp_ff          <= fp_in;
         frame0_ff      <= frame0_in;
         clear_ff       <= clear_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req.operation);
         value_ff <= req.value;
         idx_ff   <= req.local_index;
         maddr_ff <= req.method_addr;
         nargs_ff <= req.arg_count;
         nloc_ff  <= req.local_count;
         cpc_ff   <= req.current_pc;
      end
      walk_ff   <= walk_in;
      wbase_ff  <= wbase_in;
      sbase_ff  <= sbase_in;
      data_ff   <= data_in;
      npc_ff    <= npc_in;
      pcv_ff    <= pcv_in;
      status_ff <= status_in;
   end

   // Operand memory
   always_ff @(posedge clock) begin
      if (op_we) operand_mem[op_waddr] <= op_wdata;
      op_rdata <= operand_mem[op_raddr];
   end

   // Locals memory and written flags
   always_ff @(posedge clock) begin
      if (loc_we) locals_mem[loc_waddr] <= loc_wdata;
      loc_rdata <= locals_mem[local_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_we) written_mem[wr_waddr] <= wr_wdata;
      wr_rdata <= written_mem[local_addr];
   end

   // Frame memory
   always_ff @(posedge clock) begin
      if (fr_we) begin
         fbase_mem[fr_waddr] <= wbase_ff;
         fsize_mem[fr_waddr] <= total;
         fpc_mem[fr_waddr]   <= cpc_ff;
         ffp_mem[fr_waddr]   <= fp_ff;
      end
      fbase_rdata <= fbase_mem[fr_raddr];
      fsize_rdata <= fsize_mem[fr_raddr];
      fpc_rdata   <= fpc_mem[fr_raddr];
      ffp_rdata   <= ffp_mem[fr_raddr];
   end

   // Checks
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= SCW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_frame_bound: assert property (@(posedge clock) disable iff (reset)
      frame_count_ff <= FCW'(FRAME_LIMIT))
      else $error("frame count beyond limit");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("request taken while a response is pending");

   a_invoke_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH |=> frame_count_ff == $past(frame_count_ff) + FCW'(1))
      else $error("invoke did not open a frame");

endmodule
